// ----- rtl/core/crrc_pkg.sv -----
// Shared constants, types and coefficient table for the circle versus rotated rectangle test.
package crrc_pkg;

  localparam int COORD_BITS  = 32;
  localparam int SIZE_BITS   = COORD_BITS - 1;
  localparam int ANGLE_BITS  = 16;
  localparam int TRIG_FRAC   = 30;
  localparam int MAG_BITS    = TRIG_FRAC + 1;
  localparam int HORNER_BITS = 32;
  localparam int XW          = COORD_BITS + 6;
  localparam int NUM_STAGES  = 16;

  localparam logic [ANGLE_BITS-1:0] QUARTER  = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [MAG_BITS-1:0]   TRIG_ONE = MAG_BITS'(1) << TRIG_FRAC;

  // Odd polynomial of sin(pi/2 * x), from the x^11 term down to the x term, in Q2.30.
  localparam logic [HORNER_BITS-1:0] SIN_COEF [0:5] = '{
    32'd3864, 32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  typedef struct packed {
    logic [MAG_BITS-1:0] cm;
    logic [MAG_BITS-1:0] sm;
    logic                cn;
    logic                sn;
  } trig_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [SIZE_BITS-1:0]         dia;
    logic signed [XW-1:0]         lx;
    logic signed [XW-1:0]         ly;
    logic signed [XW-1:0]         hx;
    logic signed [XW-1:0]         hy;
    logic signed [COORD_BITS-1:0] ox;
    logic signed [COORD_BITS-1:0] oy;
    logic signed [XW-1:0]         dx1;
    logic signed [XW-1:0]         dy1;
    logic [ANGLE_BITS-1:0]        ang;
    logic                         zero;
  } pay_t;

endpackage

// ----- rtl/core/crrc_trig.sv -----
// Pipelined sine magnitude and sign from a turn fraction, by a Horner polynomial.
module crrc_trig (
  input  logic                               clk,
  input  logic [6:0]                         en,
  input  logic [crrc_pkg::ANGLE_BITS-1:0]    angle,
  output logic [crrc_pkg::MAG_BITS-1:0]      mag,
  output logic                               neg
);
  import crrc_pkg::*;

  localparam int QW = ANGLE_BITS - 2;
  localparam int PW = HORNER_BITS + MAG_BITS;

  logic [1:0]              q;
  logic [MAG_BITS-1:0]     x0;
  logic [2*MAG_BITS-1:0]   xx;
  logic [MAG_BITS-1:0]     xr  [0:5];
  logic [MAG_BITS-1:0]     x2r [0:4];
  logic                    q1r [0:5];
  logic [HORNER_BITS-1:0]  hr  [1:5];
  logic [PW-1:0]           fprod;
  logic [PW-TRIG_FRAC-1:0] fval;
  logic [MAG_BITS-1:0]     capped;

  always_comb begin
    q  = angle[ANGLE_BITS-1 -: 2];
    x0 = MAG_BITS'(angle[QW-1:0]) << (TRIG_FRAC - QW);
    if (q[0]) begin
      x0 = TRIG_ONE - x0;
    end
    xx = (2*MAG_BITS)'(x0) * (2*MAG_BITS)'(x0);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xr[0]  <= x0;
      x2r[0] <= xx[TRIG_FRAC +: MAG_BITS];
      q1r[0] <= q[1];
    end
  end

  for (genvar i = 1; i <= 5; i++) begin : g_horner
    logic [HORNER_BITS-1:0] hp;
    logic [PW-1:0]          prod;
    if (i == 1) begin : g_first
      assign hp = SIN_COEF[0];
    end else begin : g_rest
      assign hp = hr[i-1];
    end
    assign prod = PW'(hp) * PW'(x2r[i-1]);
    always_ff @(posedge clk) begin
      if (en[i]) begin
        hr[i]  <= SIN_COEF[i] - prod[TRIG_FRAC +: HORNER_BITS];
        xr[i]  <= xr[i-1];
        q1r[i] <= q1r[i-1];
      end
    end
    if (i <= 4) begin : g_x2
      always_ff @(posedge clk) begin
        if (en[i]) begin
          x2r[i] <= x2r[i-1];
        end
      end
    end
  end

  always_comb begin
    fprod  = PW'(hr[5]) * PW'(xr[5]);
    fval   = fprod[PW-1:TRIG_FRAC];
    capped = (fval > (PW-TRIG_FRAC)'(TRIG_ONE)) ? TRIG_ONE : fval[MAG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      mag <= capped;
      neg <= q1r[5] && (capped != '0);
    end
  end

endmodule

// ----- rtl/core/crrc_rot.sv -----
// Two-stage rotation of an offset vector about an origin by signed trig magnitudes.
module crrc_rot (
  input  logic                                 clk,
  input  logic [1:0]                           en,
  input  logic signed [crrc_pkg::XW-1:0]       dx,
  input  logic signed [crrc_pkg::XW-1:0]       dy,
  input  logic signed [crrc_pkg::COORD_BITS-1:0] ox,
  input  logic signed [crrc_pkg::COORD_BITS-1:0] oy,
  input  crrc_pkg::trig_t                      tr,
  output logic signed [crrc_pkg::XW-1:0]       px,
  output logic signed [crrc_pkg::XW-1:0]       py
);
  import crrc_pkg::*;

  localparam int PW = XW + MAG_BITS + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (TRIG_FRAC - 1);

  logic signed [MAG_BITS:0]     cms;
  logic signed [MAG_BITS:0]     sms;
  logic signed [PW-1:0]         pcx, psy, psx, pcy;
  logic signed [COORD_BITS-1:0] ox_r, oy_r;
  logic                         cn_r, sn_r;

  // Rounds half up to a whole coordinate unit, then applies the trig sign.
  function automatic logic signed [XW-1:0] rnd(input logic signed [PW-1:0] p, input logic ng);
    logic signed [PW-1:0] t;
    t = (p + signed'(HALF)) >>> TRIG_FRAC;
    return ng ? -t[XW-1:0] : t[XW-1:0];
  endfunction

  assign cms = signed'({1'b0, tr.cm});
  assign sms = signed'({1'b0, tr.sm});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pcx  <= PW'(dx) * PW'(cms);
      psy  <= PW'(dy) * PW'(sms);
      psx  <= PW'(dx) * PW'(sms);
      pcy  <= PW'(dy) * PW'(cms);
      ox_r <= ox;
      oy_r <= oy;
      cn_r <= tr.cn;
      sn_r <= tr.sn;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      px <= rnd(pcx, cn_r) - rnd(psy, sn_r) + XW'(ox_r);
      py <= rnd(psx, sn_r) + rnd(pcy, cn_r) + XW'(oy_r);
    end
  end

endmodule

// ----- rtl/core/crrc_dist.sv -----
// Distance test of the closest point against the circle radius, with the result register.
module crrc_dist (
  input  logic                                   clk,
  input  logic [2:0]                             en,
  input  logic signed [crrc_pkg::XW-1:0]         px,
  input  logic signed [crrc_pkg::XW-1:0]         py,
  input  logic signed [crrc_pkg::COORD_BITS-1:0] cx,
  input  logic signed [crrc_pkg::COORD_BITS-1:0] cy,
  input  logic [crrc_pkg::SIZE_BITS-1:0]         dia,
  output logic                                   hit,
  output logic signed [crrc_pkg::COORD_BITS-1:0] diff_x,
  output logic signed [crrc_pkg::COORD_BITS-1:0] diff_y
);
  import crrc_pkg::*;

  localparam int SW = 2 * COORD_BITS;

  logic signed [XW-1:0]         dx, dy;
  logic [XW-1:0]                ax, ay;
  logic                         near1, near2;
  logic [COORD_BITS-1:0]        ax_r, ay_r;
  logic [SIZE_BITS-1:0]         dia_r;
  logic signed [COORD_BITS-1:0] dx1, dy1, dx2, dy2;
  logic [SW-1:0]                sqx, sqy, sqd;
  logic [SW:0]                  sum;
  logic                         is_hit;

  always_comb begin
    dx = px - XW'(cx);
    dy = py - XW'(cy);
    ax = (dx[XW-1] ? -dx : dx) << 1;
    ay = (dy[XW-1] ? -dy : dy) << 1;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      near1 <= (ax <= XW'(dia)) && (ay <= XW'(dia));
      ax_r  <= ax[COORD_BITS-1:0];
      ay_r  <= ay[COORD_BITS-1:0];
      dia_r <= dia;
      dx1   <= dx[COORD_BITS-1:0];
      dy1   <= dy[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sqx   <= SW'(ax_r) * SW'(ax_r);
      sqy   <= SW'(ay_r) * SW'(ay_r);
      sqd   <= SW'(dia_r) * SW'(dia_r);
      near2 <= near1;
      dx2   <= dx1;
      dy2   <= dy1;
    end
  end

  always_comb begin
    sum    = (SW+1)'(sqx) + (SW+1)'(sqy);
    is_hit = near2 && (sum <= (SW+1)'(sqd));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      hit    <= is_hit;
      diff_x <= is_hit ? dx2 : '0;
      diff_y <= is_hit ? dy2 : '0;
    end
  end

endmodule

// ----- rtl/core/circle_rotated_rect_collision_top.sv -----
// Top level of the circle versus rotated rectangle collision pipeline.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid / in_ready    circle, rectangle and rotation angle
//   output    out        out_valid / out_ready  hit, diff_x, diff_y
//
// One beat enters per cycle while in_ready is high. It passes through sixteen register
// stages before its result is valid at the output. The depth is set by the seven multiplies
// of the sine polynomial, the two rotations and the squared compare.
// Every stage has its own valid bit and advances when it is empty or the next stage
// advances, so a stall at the output fills bubbles first and never drops or repeats a beat.
// The rst input is synchronous and clears only the valid bits; the data registers
// simply carry whatever last passed through them.
// A zero angle forces an exact unit cosine and a zero sine, which leaves both rotations
// as exact identities.
module circle_rotated_rect_collision_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [crrc_pkg::COORD_BITS-1:0] circle_x,
  input  logic signed [crrc_pkg::COORD_BITS-1:0] circle_y,
  input  logic [crrc_pkg::SIZE_BITS-1:0]         circle_diameter,
  input  logic signed [crrc_pkg::COORD_BITS-1:0] rect_left_x,
  input  logic signed [crrc_pkg::COORD_BITS-1:0] rect_low_y,
  input  logic [crrc_pkg::SIZE_BITS-1:0]         rect_width,
  input  logic [crrc_pkg::SIZE_BITS-1:0]         rect_height,
  input  logic signed [crrc_pkg::COORD_BITS-1:0] rect_center_x,
  input  logic signed [crrc_pkg::COORD_BITS-1:0] rect_center_y,
  input  logic [crrc_pkg::ANGLE_BITS-1:0]        rotation_angle,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   hit,
  output logic signed [crrc_pkg::COORD_BITS-1:0] diff_x,
  output logic signed [crrc_pkg::COORD_BITS-1:0] diff_y
);
  import crrc_pkg::*;

  // Valid bit per stage and the load enable of each stage.
  logic [NUM_STAGES:1] v;
  logic [NUM_STAGES:1] en;

  // Operands that travel with the beat until the distance stage.
  pay_t pay [1:13];

  logic [MAG_BITS-1:0]  smag, cmag;
  logic                 sneg, cneg;
  logic [ANGLE_BITS-1:0] ang_cos;
  trig_t                tr8;
  trig_t                tr [9:11];
  trig_t                tr_back;

  logic signed [XW-1:0] px1, py1, px2, py2;
  logic signed [XW-1:0] cpx, cpy;
  logic signed [XW-1:0] dx2, dy2;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    en[NUM_STAGES] = !v[NUM_STAGES] || out_ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1 registers the beat and forms the rectangle bounds and the offset from the
  // rotation origin.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pay[1].cx   <= circle_x;
      pay[1].cy   <= circle_y;
      pay[1].dia  <= circle_diameter;
      pay[1].lx   <= XW'(rect_left_x);
      pay[1].ly   <= XW'(rect_low_y);
      pay[1].hx   <= XW'(rect_left_x) + XW'(rect_width);
      pay[1].hy   <= XW'(rect_low_y) + XW'(rect_height);
      pay[1].ox   <= rect_center_x;
      pay[1].oy   <= rect_center_y;
      pay[1].dx1  <= XW'(circle_x) - XW'(rect_center_x);
      pay[1].dy1  <= XW'(circle_y) - XW'(rect_center_y);
      pay[1].ang  <= rotation_angle;
      pay[1].zero <= (rotation_angle == '0);
    end
  end

  for (genvar k = 2; k <= 13; k++) begin : g_pay
    always_ff @(posedge clk) begin
      if (en[k]) begin
        pay[k] <= pay[k-1];
      end
    end
  end

  // Stages 2 to 8: sine and cosine, the cosine being the sine a quarter turn ahead.
  assign ang_cos = pay[1].ang + QUARTER;

  crrc_trig u_sin (
    .clk   (clk),
    .en    (en[8:2]),
    .angle (pay[1].ang),
    .mag   (smag),
    .neg   (sneg)
  );

  crrc_trig u_cos (
    .clk   (clk),
    .en    (en[8:2]),
    .angle (ang_cos),
    .mag   (cmag),
    .neg   (cneg)
  );

  always_comb begin
    if (pay[8].zero) begin
      tr8 = '{cm: TRIG_ONE, sm: '0, cn: 1'b0, sn: 1'b0};
    end else begin
      tr8 = '{cm: cmag, sm: smag, cn: cneg, sn: sneg};
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      tr[9] <= tr8;
    end
    if (en[10]) begin
      tr[10] <= tr[9];
    end
    if (en[11]) begin
      tr[11] <= tr[10];
    end
  end

  // Stages 9 and 10 turn the circle center into the rectangle frame.
  crrc_rot u_rot_in (
    .clk (clk),
    .en  (en[10:9]),
    .dx  (pay[8].dx1),
    .dy  (pay[8].dy1),
    .ox  (pay[8].ox),
    .oy  (pay[8].oy),
    .tr  (tr8),
    .px  (px1),
    .py  (py1)
  );

  // Stage 11 clamps to the rectangle and takes the offset for the way back.
  always_comb begin
    cpx = (px1 < pay[10].lx) ? pay[10].lx : ((px1 > pay[10].hx) ? pay[10].hx : px1);
    cpy = (py1 < pay[10].ly) ? pay[10].ly : ((py1 > pay[10].hy) ? pay[10].hy : py1);
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      dx2 <= cpx - XW'(pay[10].ox);
      dy2 <= cpy - XW'(pay[10].oy);
    end
  end

  // The back rotation uses the same cosine and the opposite sine.
  always_comb begin
    tr_back    = tr[11];
    tr_back.sn = !tr[11].sn;
  end

  // Stages 12 and 13 rotate the closest point back to the world frame.
  crrc_rot u_rot_out (
    .clk (clk),
    .en  (en[13:12]),
    .dx  (dx2),
    .dy  (dy2),
    .ox  (pay[11].ox),
    .oy  (pay[11].oy),
    .tr  (tr_back),
    .px  (px2),
    .py  (py2)
  );

  // Stages 14 to 16 compare the squared distance and hold the result.
  crrc_dist u_dist (
    .clk    (clk),
    .en     (en[16:14]),
    .px     (px2),
    .py     (py2),
    .cx     (pay[13].cx),
    .cy     (pay[13].cy),
    .dia    (pay[13].dia),
    .hit    (hit),
    .diff_x (diff_x),
    .diff_y (diff_y)
  );

endmodule
